@@ src/grid_hole_extrapolation_fill_assert.svh @@
// Assertion macros for the grid hole fill block.
`ifndef GRID_HOLE_EXTRAPOLATION_FILL_ASSERT_SVH
`define GRID_HOLE_EXTRAPOLATION_FILL_ASSERT_SVH

`ifndef SYNTHESIS
`define GHEF_ASSERT(lbl, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error("grid fill check failed");
`define GHEF_ASSERT_RST(lbl, prop) \
	lbl: assert property (@(posedge clk) prop) \
		else $error("grid fill reset check failed");
`else
`define GHEF_ASSERT(lbl, prop)
`define GHEF_ASSERT_RST(lbl, prop)
`endif

`endif

@@ src/ghef_pkg.sv @@
package ghef_pkg;

	localparam int COORD_W = 32;
	// 4 estimates of 2*near - far need 36 signed bits
	localparam int SUM_W   = 36;
	localparam int CFG_W   = 7;
	localparam int HOLE_W  = 13;

	localparam logic [1:0] OP_WRITE = 2'd0;
	localparam logic [1:0] OP_FILL  = 2'd1;
	localparam logic [1:0] OP_READ  = 2'd2;

	localparam logic REG_ROWS = 1'b0;
	localparam logic REG_COLS = 1'b1;

	localparam logic [1:0] DIR_UP    = 2'd0;
	localparam logic [1:0] DIR_DOWN  = 2'd1;
	localparam logic [1:0] DIR_LEFT  = 2'd2;
	localparam logic [1:0] DIR_RIGHT = 2'd3;

	typedef struct packed {
		logic                        vld;
		logic [2:0][COORD_W-1:0]     c;
	} point_t;

	typedef struct packed {
		logic       start;
		logic [2:0] n;
	} div_ctl_t;

	typedef struct packed {
		logic busy;
		logic done;
	} div_sts_t;

endpackage

@@ src/ghef_store.sv @@
module ghef_store import ghef_pkg::*; #(
	parameter int DEPTH = 4096,
	parameter int AW    = 12
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  point_t        wdata,
	input  logic [AW-1:0] raddr,
	output point_t        rdata
);

	point_t mem_q [DEPTH];
	point_t rdata_q;

	// one write port, one registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

@@ src/ghef_div.sv @@
module ghef_div import ghef_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	input  div_ctl_t                ctl,
	input  logic [2:0][SUM_W-1:0]   sum,
	output div_sts_t                sts,
	output logic [2:0][COORD_W-1:0] quo
);

	localparam int CNT_W = $clog2(SUM_W + 1);
	localparam logic [SUM_W-1:0] POS_MAX = SUM_W'(64'h7FFF_FFFF);
	localparam logic [SUM_W-1:0] NEG_MAX = SUM_W'(64'h8000_0000);

	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic             done_q;
	logic [2:0]       n_q;
	logic [SUM_W-1:0] mag_q [3];
	logic [1:0]       rem_q [3];
	logic             neg_q [3];
	logic [2:0]       rs    [3];
	logic             ge    [3];

	// bit counter: one quotient bit per cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= busy_q && !ctl.start && (cnt_q == CNT_W'(1));
			if (ctl.start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(SUM_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CNT_W'(1);
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	// restoring step on the magnitude, three lanes side by side
	always_comb begin
		for (int k = 0; k < 3; k++) begin
			rs[k] = {rem_q[k], mag_q[k][SUM_W-1]};
			ge[k] = rs[k] >= n_q;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.start) begin
			n_q <= ctl.n;
			for (int k = 0; k < 3; k++) begin
				neg_q[k] <= sum[k][SUM_W-1];
				mag_q[k] <= sum[k][SUM_W-1] ? (~sum[k] + SUM_W'(1)) : sum[k];
				rem_q[k] <= '0;
			end
		end else if (busy_q) begin
			for (int k = 0; k < 3; k++) begin
				mag_q[k] <= {mag_q[k][SUM_W-2:0], ge[k]};
				rem_q[k] <= ge[k] ? 2'(rs[k] - n_q) : 2'(rs[k]);
			end
		end
	end

	// sign and saturate to 32 bits
	always_comb begin
		for (int k = 0; k < 3; k++) begin
			if (neg_q[k]) begin
				quo[k] = (mag_q[k] > NEG_MAX) ? 32'h8000_0000
					: (~mag_q[k][COORD_W-1:0] + 32'd1);
			end else begin
				quo[k] = (mag_q[k] > POS_MAX) ? 32'h7FFF_FFFF : mag_q[k][COORD_W-1:0];
			end
		end
	end

	assign sts.busy = busy_q;
	assign sts.done = done_q;

endmodule

@@ src/grid_hole_extrapolation_fill.sv @@
// Grid hole fill for an organized grid of 3D points (signed Q16.16).
// Request channel: req_valid/req_stall with opcode, row, col, in_x/y/z, in_valid.
//   opcode 0 writes a point, 1 runs a hole fill over the active grid, 2 reads.
// Response channel: rsp_valid/rsp_stall with out_x/y/z, out_valid, holes_left.
//   Every request gives one response; holes_left is nonzero only after a fill.
// Config channel: cfg_valid/cfg_ready, cfg_index 0 rows_in_use, 1 cols_in_use.
//   Always ready, may be written at any time the block is idle.
// Write responses are loaded at accept, read responses in ST_RD. A fill takes
//   each cell through ST_CENTER, ST_CHECK and ST_NEXT; a hole adds ST_NEAR per
//   direction, ST_NEARW per neighbor inside the grid, ST_FARW per far read and
//   ST_EVAL, then ST_DIV (serial divider) and ST_WRITE unless no direction is
//   usable; ST_DONE ends the fill. The store's single read port and the
//   one-bit-per-cycle divider set the pace. After reset the block clears all
//   valid bits, one entry per cycle, with req_stall high; config writes still go in.
// A response waits in the output register while rsp_stall is high; a new
//   request is taken only when that register is empty or being drained.
module grid_hole_extrapolation_fill import ghef_pkg::*; #(
	parameter int MAX_ROWS = 64,
	parameter int MAX_COLS = 64
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       req_valid,
	output logic                       req_stall,
	input  logic [1:0]                 opcode,
	input  logic [5:0]                 row,
	input  logic [5:0]                 col,
	input  logic signed [COORD_W-1:0]  in_x,
	input  logic signed [COORD_W-1:0]  in_y,
	input  logic signed [COORD_W-1:0]  in_z,
	input  logic                       in_valid,
	output logic                       rsp_valid,
	input  logic                       rsp_stall,
	output logic signed [COORD_W-1:0]  out_x,
	output logic signed [COORD_W-1:0]  out_y,
	output logic signed [COORD_W-1:0]  out_z,
	output logic                       out_valid,
	output logic [HOLE_W-1:0]          holes_left,
	input  logic                       cfg_valid,
	output logic                       cfg_ready,
	input  logic                       cfg_index,
	input  logic [CFG_W-1:0]           cfg_data
);

	localparam int DEPTH = MAX_ROWS * MAX_COLS;
	localparam int AW    = $clog2(DEPTH);
	localparam int RB    = $clog2(MAX_ROWS + 1);
	localparam int CB    = $clog2(MAX_COLS + 1);
	localparam int GB    = (RB > CB) ? RB : CB;
	localparam int GW    = ((GB > CFG_W) ? GB : CFG_W) + 1;
	localparam logic [AW-1:0] COLS_A  = AW'(MAX_COLS);
	localparam logic [AW-1:0] COLS2_A = AW'(2 * MAX_COLS);
	localparam logic [AW-1:0] LAST_A  = AW'(DEPTH - 1);

	typedef enum logic [12:0] {
		ST_IDLE   = 13'b0000000000001,
		ST_CLEAR  = 13'b0000000000010,
		ST_RD     = 13'b0000000000100,
		ST_CENTER = 13'b0000000001000,
		ST_CHECK  = 13'b0000000010000,
		ST_NEAR   = 13'b0000000100000,
		ST_NEARW  = 13'b0000001000000,
		ST_FARW   = 13'b0000010000000,
		ST_EVAL   = 13'b0000100000000,
		ST_DIV    = 13'b0001000000000,
		ST_WRITE  = 13'b0010000000000,
		ST_NEXT   = 13'b0100000000000,
		ST_DONE   = 13'b1000000000000
	} state_t;

	state_t              state_q, st_d;
	logic [CFG_W-1:0]    rows_q, cols_q;
	logic [AW-1:0]       clr_q, cell_q, base_q;
	logic [GW-1:0]       r_q, c_q, nr, nc;
	logic [1:0]          dir_q;
	logic [2:0]          n_q;
	logic [HOLE_W-1:0]   holes_q;
	logic                rsp_valid_q, rd_in_q;

	logic                req_acc, req_in, grid_empty;
	logic [AW-1:0]       req_idx, near_a, far_a;
	logic                near_in, far_in, dir_last, dir_step, more_c, more_r, load_out;

	logic                mem_we;
	logic [AW-1:0]       mem_wa, mem_ra;
	point_t              mem_wd, rd;

	div_ctl_t                  div_ctl;
	div_sts_t                  div_sts;
	logic [2:0][SUM_W-1:0]     sum_q;
	logic [2:0][COORD_W-1:0]   quo;
	logic [2:0][COORD_W-1:0]   near_q;
	logic [SUM_W-1:0]          near_e [3];
	logic [SUM_W-1:0]          far_e  [3];

	logic signed [COORD_W-1:0] out_x_q, out_y_q, out_z_q;
	logic                      out_valid_q;
	logic [HOLE_W-1:0]         holes_out_q;

	// request decode
	assign req_stall  = (state_q != ST_IDLE) || (rsp_valid_q && rsp_stall);
	assign req_acc    = req_valid && !req_stall;
	assign req_in     = (GW'(row) < GW'(MAX_ROWS)) && (GW'(col) < GW'(MAX_COLS));
	assign req_idx    = AW'(row) * COLS_A + AW'(col);
	assign cfg_ready  = 1'b1;

	// active grid, clamped to the store
	assign nr = (GW'(rows_q) > GW'(MAX_ROWS)) ? GW'(MAX_ROWS) : GW'(rows_q);
	assign nc = (GW'(cols_q) > GW'(MAX_COLS)) ? GW'(MAX_COLS) : GW'(cols_q);
	assign grid_empty = (nr == '0) || (nc == '0);
	assign more_c = (c_q + GW'(1)) < nc;
	assign more_r = (r_q + GW'(1)) < nr;

	// neighbor addresses and bounds for the current direction
	always_comb begin
		unique case (dir_q)
			DIR_UP: begin
				near_in = r_q >= GW'(1);
				far_in  = r_q >= GW'(2);
				near_a  = cell_q - COLS_A;
				far_a   = cell_q - COLS2_A;
			end
			DIR_DOWN: begin
				near_in = (r_q + GW'(1)) < nr;
				far_in  = (r_q + GW'(2)) < nr;
				near_a  = cell_q + COLS_A;
				far_a   = cell_q + COLS2_A;
			end
			DIR_LEFT: begin
				near_in = c_q >= GW'(1);
				far_in  = c_q >= GW'(2);
				near_a  = cell_q - AW'(1);
				far_a   = cell_q - AW'(2);
			end
			default: begin
				near_in = (c_q + GW'(1)) < nc;
				far_in  = (c_q + GW'(2)) < nc;
				near_a  = cell_q + AW'(1);
				far_a   = cell_q + AW'(2);
			end
		endcase
	end

	assign dir_last = dir_q == DIR_RIGHT;
	assign dir_step = (state_q == ST_NEAR && !near_in)
		|| (state_q == ST_NEARW && (!rd.vld || !far_in))
		|| (state_q == ST_FARW);
	assign load_out = (state_q == ST_IDLE && req_acc && opcode != OP_FILL && opcode != OP_READ)
		|| (state_q == ST_RD) || (state_q == ST_DONE);

	// sequencer and store port control
	always_comb begin
		st_d   = state_q;
		mem_we = 1'b0;
		mem_wa = cell_q;
		mem_wd = '0;
		mem_ra = cell_q;
		unique case (state_q)
			ST_IDLE: begin
				mem_ra = req_idx;
				if (req_acc) begin
					unique case (opcode)
						OP_WRITE: begin
							mem_we      = req_in;
							mem_wa      = req_idx;
							mem_wd.vld  = in_valid;
							mem_wd.c[0] = in_x;
							mem_wd.c[1] = in_y;
							mem_wd.c[2] = in_z;
						end
						OP_FILL: st_d = grid_empty ? ST_DONE : ST_CENTER;
						OP_READ: st_d = ST_RD;
						default: st_d = ST_IDLE;
					endcase
				end
			end
			ST_CLEAR: begin
				mem_we = 1'b1;
				mem_wa = clr_q;
				if (clr_q == LAST_A) st_d = ST_IDLE;
			end
			ST_RD:     st_d = ST_IDLE;
			ST_CENTER: st_d = ST_CHECK;
			ST_CHECK:  st_d = rd.vld ? ST_NEXT : ST_NEAR;
			ST_NEAR: begin
				mem_ra = near_a;
				if (near_in) st_d = ST_NEARW;
				else         st_d = dir_last ? ST_EVAL : ST_NEAR;
			end
			ST_NEARW: begin
				mem_ra = far_a;
				if (rd.vld && far_in) st_d = ST_FARW;
				else                  st_d = dir_last ? ST_EVAL : ST_NEAR;
			end
			ST_FARW: st_d = dir_last ? ST_EVAL : ST_NEAR;
			ST_EVAL: st_d = (n_q == '0) ? ST_NEXT : ST_DIV;
			ST_DIV:  st_d = div_sts.done ? ST_WRITE : ST_DIV;
			ST_WRITE: begin
				mem_we     = 1'b1;
				mem_wd.vld = 1'b1;
				mem_wd.c   = quo;
			end
			ST_NEXT:  st_d = (more_c || more_r) ? ST_CENTER : ST_DONE;
			ST_DONE:  st_d = ST_IDLE;
			default:  st_d = ST_IDLE;
		endcase
		if (state_q == ST_WRITE) st_d = ST_NEXT;
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			clr_q       <= '0;
			rows_q      <= CFG_W'(45);
			cols_q      <= CFG_W'(45);
			r_q         <= '0;
			c_q         <= '0;
			cell_q      <= '0;
			base_q      <= '0;
			dir_q       <= DIR_UP;
			n_q         <= '0;
			holes_q     <= '0;
			rsp_valid_q <= 1'b0;
			rd_in_q     <= 1'b0;
		end else begin
			state_q <= st_d;
			if (state_q == ST_CLEAR) clr_q <= clr_q + AW'(1);
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == REG_ROWS) rows_q <= cfg_data;
				else                       cols_q <= cfg_data;
			end
			if (state_q == ST_IDLE && req_acc) begin
				rd_in_q <= req_in;
				if (opcode == OP_FILL) begin
					r_q     <= '0;
					c_q     <= '0;
					cell_q  <= '0;
					base_q  <= '0;
					holes_q <= '0;
				end
			end
			if (state_q == ST_CHECK) begin
				dir_q <= DIR_UP;
				n_q   <= '0;
			end
			if (dir_step && !dir_last) dir_q <= dir_q + 2'd1;
			if (state_q == ST_NEARW && rd.vld) n_q <= n_q + 3'd1;
			if (state_q == ST_EVAL && n_q == '0 && holes_q != '1) holes_q <= holes_q + HOLE_W'(1);
			if (state_q == ST_NEXT) begin
				if (more_c) begin
					c_q    <= c_q + GW'(1);
					cell_q <= cell_q + AW'(1);
				end else if (more_r) begin
					r_q    <= r_q + GW'(1);
					c_q    <= '0;
					base_q <= base_q + COLS_A;
					cell_q <= base_q + COLS_A;
				end
			end
			if (load_out)       rsp_valid_q <= 1'b1;
			else if (!rsp_stall) rsp_valid_q <= 1'b0;
		end
	end

	// estimate terms, sign-extended
	always_comb begin
		for (int k = 0; k < 3; k++) begin
			near_e[k] = SUM_W'($signed(near_q[k]));
			far_e[k]  = SUM_W'($signed(rd.c[k]));
		end
	end

	// accumulators and response payload
	always_ff @(posedge clk) begin
		if (state_q == ST_CHECK) sum_q <= '0;
		if (state_q == ST_NEARW && rd.vld) begin
			if (far_in) begin
				near_q <= rd.c;
			end else begin
				for (int k = 0; k < 3; k++) begin
					sum_q[k] <= sum_q[k] + SUM_W'($signed(rd.c[k]));
				end
			end
		end
		if (state_q == ST_FARW) begin
			for (int k = 0; k < 3; k++) begin
				if (rd.vld) sum_q[k] <= sum_q[k] + (near_e[k] << 1) - far_e[k];
				else        sum_q[k] <= sum_q[k] + near_e[k];
			end
		end
		if (load_out) begin
			if (state_q == ST_RD && rd_in_q && rd.vld) begin
				out_x_q     <= rd.c[0];
				out_y_q     <= rd.c[1];
				out_z_q     <= rd.c[2];
				out_valid_q <= 1'b1;
			end else begin
				out_x_q     <= '0;
				out_y_q     <= '0;
				out_z_q     <= '0;
				out_valid_q <= 1'b0;
			end
			holes_out_q <= (state_q == ST_DONE) ? holes_q : '0;
		end
	end

	assign div_ctl.start = (state_q == ST_EVAL) && (n_q != '0);
	assign div_ctl.n     = n_q;

	ghef_store #(.DEPTH(DEPTH), .AW(AW)) u_store (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_wa),
		.wdata (mem_wd),
		.raddr (mem_ra),
		.rdata (rd)
	);

	ghef_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (div_ctl),
		.sum    (sum_q),
		.sts    (div_sts),
		.quo    (quo)
	);

	assign rsp_valid  = rsp_valid_q;
	assign out_x      = out_x_q;
	assign out_y      = out_y_q;
	assign out_z      = out_z_q;
	assign out_valid  = out_valid_q;
	assign holes_left = holes_out_q;

`include "grid_hole_extrapolation_fill_assert.svh"

	// divider runs only while the sequencer waits on it
	`GHEF_ASSERT(a_div_owned, div_sts.busy |-> state_q == ST_DIV)
	// a read is answered once it has passed through ST_RD
	`GHEF_ASSERT(a_read_lat, req_acc && opcode == OP_READ |=> ##1 rsp_valid)
	// a fill report carries no point
	`GHEF_ASSERT(a_fill_clean, rsp_valid && holes_left != '0 |-> !out_valid && out_x == '0)

endmodule
